// ===== rtl/mfba_pkg.sv =====
// shared types and constants for the max flow bfs augment unit
`default_nettype none
package mfba_pkg;
    localparam int VERT_W  = 6;
    localparam int NVERT   = 64;
    localparam int CAP_W   = 16;
    localparam int ADDR_W  = 2 * VERT_W;
    localparam int AMT_W   = 24;
    localparam int CNT_W   = VERT_W + 1;

    localparam logic [AMT_W-1:0] SOURCE_AMOUNT = 24'd9999999;
    localparam logic [AMT_W-1:0] OUT_MAX       = 24'hFFFFFF;
    localparam logic [CNT_W-1:0] VCOUNT_RESET  = 7'd64;
    localparam logic [CNT_W-1:0] VCOUNT_MIN    = 7'd2;
    localparam logic [CNT_W-1:0] VCOUNT_MAX    = 7'd64;

    localparam logic OP_LOAD    = 1'b0;
    localparam logic OP_COMPUTE = 1'b1;

    // one label entry: direction, predecessor and residual amount
    typedef struct packed {
        logic              fwd;
        logic [VERT_W-1:0] pred;
        logic [AMT_W-1:0]  amt;
    } label_t;
endpackage
`default_nettype wire

// ===== rtl/max_flow_bfs_augment_unit.sv =====
// top level: edmonds-karp maximum flow over a capacity matrix in memory
//
//  channel  | direction | handshake          | payload
//  s_       | in        | s_valid / s_ready  | s_op, s_from_vertex, s_to_vertex, s_capacity,
//           |           |                    | s_source, s_sink
//  m_       | out       | m_valid / m_ready  | m_max_flow
//  cfg_     | in        | cfg_we             | cfg_wdata (vertex count)
//
// a load transfer writes the capacity memory from the idle state, which stays ready. a compute first
// clears the flow memory, then repeats a breadth-first labelling search from the source
// and an augmentation back along the labelled path, until the sink is no longer reached.
// after reset a clearing pass zeroes the capacity memory with s_ready low.
// a finished result sits in the output register; loads are taken while it waits.
`default_nettype none
module max_flow_bfs_augment_unit (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        cfg_we,
    input  wire logic [mfba_pkg::CNT_W-1:0]  cfg_wdata,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic                        s_op,
    input  wire logic [mfba_pkg::VERT_W-1:0] s_from_vertex,
    input  wire logic [mfba_pkg::VERT_W-1:0] s_to_vertex,
    input  wire logic [mfba_pkg::CAP_W-1:0]  s_capacity,
    input  wire logic [mfba_pkg::VERT_W-1:0] s_source,
    input  wire logic [mfba_pkg::VERT_W-1:0] s_sink,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic [mfba_pkg::AMT_W-1:0]       m_max_flow
);
    import mfba_pkg::*;

    localparam logic [3:0] ST_CLR_CAP  = 4'd0;
    localparam logic [3:0] ST_IDLE     = 4'd1;
    localparam logic [3:0] ST_CLR_FLOW = 4'd2;
    localparam logic [3:0] ST_BFS_INIT = 4'd3;
    localparam logic [3:0] ST_POP      = 4'd4;
    localparam logic [3:0] ST_POP_WAIT = 4'd5;
    localparam logic [3:0] ST_AMT      = 4'd6;
    localparam logic [3:0] ST_SCAN     = 4'd7;
    localparam logic [3:0] ST_AUG_SRT  = 4'd8;
    localparam logic [3:0] ST_AUG_AMT  = 4'd9;
    localparam logic [3:0] ST_AUG_STEP = 4'd10;
    localparam logic [3:0] ST_AUG_RD   = 4'd11;
    localparam logic [3:0] ST_AUG_WR   = 4'd12;
    localparam logic [3:0] ST_DONE     = 4'd13;

    // memories
    logic [CAP_W-1:0]  cap_mem  [NVERT*NVERT];
    logic [CAP_W-1:0]  flow_mem [NVERT*NVERT];
    label_t            lbl_mem  [NVERT];
    logic [VERT_W-1:0] q_mem    [NVERT];

    logic              cap_we, flow_we, lbl_we, q_we;
    logic [ADDR_W-1:0] cap_waddr, cap_raddr, flow_waddr, flow_raddr_a, flow_raddr_b;
    logic [CAP_W-1:0]  cap_wdata, flow_wdata, cap_rdata, flow_rdata_a, flow_rdata_b;
    logic [VERT_W-1:0] lbl_waddr, lbl_raddr, q_waddr, q_raddr, q_wdata, q_rdata;
    label_t            lbl_wdata, lbl_rdata;

    // control and datapath registers
    logic [3:0]        state_reg, state_next;
    logic [ADDR_W-1:0] ctr_reg, ctr_next;
    logic [VERT_W-1:0] src_reg, src_next, snk_reg, snk_next, x_reg, x_next;
    logic [AMT_W-1:0]  amtx_reg, amtx_next;
    logic [CAP_W-1:0]  aug_amt_reg, aug_amt_next;
    logic [AMT_W-1:0]  total_reg, total_next;
    logic [CNT_W-1:0]  head_reg, head_next, tail_reg, tail_next;
    logic [CNT_W-1:0]  scan_reg, scan_next, steps_reg, steps_next;
    logic              pend_vld_reg, pend_vld_next;
    logic [VERT_W-1:0] pend_idx_reg, pend_idx_next;
    logic [ADDR_W-1:0] aug_addr_reg, aug_addr_next;
    logic              aug_fwd_reg, aug_fwd_next;
    logic [NVERT-1:0]  labeled_reg, labeled_next;
    logic              out_vld_reg, out_vld_next;
    logic [AMT_W-1:0]  out_flow_reg, out_flow_next;
    logic [CNT_W-1:0]  vcount_reg;

    logic [CNT_W-1:0]  n_used;
    logic              diff_pos, back_pos, new_lbl;
    logic [CAP_W-1:0]  diff;
    logic [AMT_W-1:0]  fwd_amt, bwd_amt;
    logic [AMT_W:0]    sum;
    logic [ADDR_W-1:0] aug_addr;

    // vertex count register, clamped on use
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vcount_reg <= VCOUNT_RESET;
        end else if (cfg_we) begin
            vcount_reg <= cfg_wdata;
        end
    end

    always_comb begin
        if (vcount_reg < VCOUNT_MIN) begin
            n_used = VCOUNT_MIN;
        end else if (vcount_reg > VCOUNT_MAX) begin
            n_used = VCOUNT_MAX;
        end else begin
            n_used = vcount_reg;
        end
    end

    // memory ports
    always_ff @(posedge aclk) begin
        if (cap_we) begin
            cap_mem[cap_waddr] <= cap_wdata;
        end
        cap_rdata <= cap_mem[cap_raddr];
    end

    always_ff @(posedge aclk) begin
        if (flow_we) begin
            flow_mem[flow_waddr] <= flow_wdata;
        end
        flow_rdata_a <= flow_mem[flow_raddr_a];
        flow_rdata_b <= flow_mem[flow_raddr_b];
    end

    always_ff @(posedge aclk) begin
        if (lbl_we) begin
            lbl_mem[lbl_waddr] <= lbl_wdata;
        end
        lbl_rdata <= lbl_mem[lbl_raddr];
    end

    always_ff @(posedge aclk) begin
        if (q_we) begin
            q_mem[q_waddr] <= q_wdata;
        end
        q_rdata <= q_mem[q_raddr];
    end

    // residual test for the vertex whose row data has just come back
    assign diff_pos = cap_rdata > flow_rdata_a;
    assign diff     = cap_rdata - flow_rdata_a;
    assign back_pos = flow_rdata_b != '0;
    assign fwd_amt  = ({{(AMT_W-CAP_W){1'b0}}, diff} < amtx_reg)
                    ? {{(AMT_W-CAP_W){1'b0}}, diff} : amtx_reg;
    assign bwd_amt  = ({{(AMT_W-CAP_W){1'b0}}, flow_rdata_b} < amtx_reg)
                    ? {{(AMT_W-CAP_W){1'b0}}, flow_rdata_b} : amtx_reg;
    assign new_lbl  = pend_vld_reg && !labeled_reg[pend_idx_reg] && (diff_pos || back_pos);

    // saturating total and augment edge address
    assign sum      = {1'b0, total_reg} + {1'b0, lbl_rdata.amt};
    assign aug_addr = lbl_rdata.fwd ? {lbl_rdata.pred, x_reg} : {x_reg, lbl_rdata.pred};

    // sequencer
    always_comb begin
        state_next    = state_reg;
        ctr_next      = ctr_reg;
        src_next      = src_reg;
        snk_next      = snk_reg;
        x_next        = x_reg;
        amtx_next     = amtx_reg;
        aug_amt_next  = aug_amt_reg;
        total_next    = total_reg;
        head_next     = head_reg;
        tail_next     = tail_reg;
        scan_next     = scan_reg;
        steps_next    = steps_reg;
        pend_vld_next = 1'b0;
        pend_idx_next = pend_idx_reg;
        aug_addr_next = aug_addr_reg;
        aug_fwd_next  = aug_fwd_reg;
        labeled_next  = labeled_reg;
        out_vld_next  = out_vld_reg && !m_ready;
        out_flow_next = out_flow_reg;

        cap_we       = 1'b0;
        cap_waddr    = ctr_reg;
        cap_wdata    = '0;
        cap_raddr    = {x_reg, scan_reg[VERT_W-1:0]};
        flow_we      = 1'b0;
        flow_waddr   = ctr_reg;
        flow_wdata   = '0;
        flow_raddr_a = {x_reg, scan_reg[VERT_W-1:0]};
        flow_raddr_b = {scan_reg[VERT_W-1:0], x_reg};
        lbl_we       = 1'b0;
        lbl_waddr    = pend_idx_reg;
        lbl_wdata    = '{fwd: diff_pos, pred: x_reg, amt: diff_pos ? fwd_amt : bwd_amt};
        lbl_raddr    = x_reg;
        q_we         = 1'b0;
        q_waddr      = tail_reg[VERT_W-1:0];
        q_wdata      = pend_idx_reg;
        q_raddr      = head_reg[VERT_W-1:0];
        s_ready      = 1'b0;

        unique case (state_reg)
            ST_CLR_CAP: begin
                cap_we   = 1'b1;
                ctr_next = ctr_reg + 1'b1;
                if (ctr_reg == '1) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (s_op == OP_LOAD) begin
                        cap_we    = 1'b1;
                        cap_waddr = {s_from_vertex, s_to_vertex};
                        cap_wdata = s_capacity;
                    end else begin
                        src_next   = s_source;
                        snk_next   = s_sink;
                        total_next = '0;
                        ctr_next   = '0;
                        if (s_source == s_sink || {1'b0, s_source} >= n_used
                            || {1'b0, s_sink} >= n_used) begin
                            state_next = ST_DONE;
                        end else begin
                            state_next = ST_CLR_FLOW;
                        end
                    end
                end
            end
            ST_CLR_FLOW: begin
                flow_we  = 1'b1;
                ctr_next = ctr_reg + 1'b1;
                if (ctr_reg == '1) begin
                    state_next = ST_BFS_INIT;
                end
            end
            ST_BFS_INIT: begin
                labeled_next          = '0;
                labeled_next[src_reg] = 1'b1;
                lbl_we                = 1'b1;
                lbl_waddr             = src_reg;
                lbl_wdata             = '{fwd: 1'b1, pred: src_reg, amt: SOURCE_AMOUNT};
                q_we                  = 1'b1;
                q_waddr               = '0;
                q_wdata               = src_reg;
                head_next             = '0;
                tail_next             = CNT_W'(1);
                state_next            = ST_POP;
            end
            ST_POP: begin
                if (head_reg < tail_reg) begin
                    head_next  = head_reg + 1'b1;
                    state_next = ST_POP_WAIT;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_POP_WAIT: begin
                x_next     = q_rdata;
                lbl_raddr  = q_rdata;
                state_next = ST_AMT;
            end
            ST_AMT: begin
                amtx_next  = lbl_rdata.amt;
                scan_next  = '0;
                state_next = ST_SCAN;
            end
            ST_SCAN: begin
                // issue the next row read while the previous one is labelled
                if (scan_reg < n_used) begin
                    scan_next     = scan_reg + 1'b1;
                    pend_vld_next = 1'b1;
                    pend_idx_next = scan_reg[VERT_W-1:0];
                end
                if (new_lbl) begin
                    lbl_we                     = 1'b1;
                    labeled_next[pend_idx_reg] = 1'b1;
                    if (tail_reg < VCOUNT_MAX) begin
                        q_we      = 1'b1;
                        tail_next = tail_reg + 1'b1;
                    end
                end
                if (scan_reg >= n_used && !pend_vld_reg) begin
                    state_next = labeled_reg[snk_reg] ? ST_AUG_SRT : ST_POP;
                end
            end
            ST_AUG_SRT: begin
                lbl_raddr  = snk_reg;
                state_next = ST_AUG_AMT;
            end
            ST_AUG_AMT: begin
                aug_amt_next = lbl_rdata.amt[CAP_W-1:0];
                total_next   = sum[AMT_W] ? OUT_MAX : sum[AMT_W-1:0];
                x_next       = snk_reg;
                steps_next   = '0;
                state_next   = ST_AUG_STEP;
            end
            ST_AUG_STEP: begin
                if (x_reg == src_reg || steps_reg >= n_used) begin
                    state_next = ST_BFS_INIT;
                end else begin
                    state_next = ST_AUG_RD;
                end
            end
            ST_AUG_RD: begin
                flow_raddr_a  = aug_addr;
                aug_addr_next = aug_addr;
                aug_fwd_next  = lbl_rdata.fwd;
                x_next        = lbl_rdata.pred;
                steps_next    = steps_reg + 1'b1;
                state_next    = ST_AUG_WR;
            end
            ST_AUG_WR: begin
                flow_we    = 1'b1;
                flow_waddr = aug_addr_reg;
                flow_wdata = aug_fwd_reg ? flow_rdata_a + aug_amt_reg
                                         : flow_rdata_a - aug_amt_reg;
                state_next = ST_AUG_STEP;
            end
            ST_DONE: begin
                if (!out_vld_reg || m_ready) begin
                    out_vld_next  = 1'b1;
                    out_flow_next = total_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLR_CAP;
            ctr_reg      <= '0;
            out_vld_reg  <= 1'b0;
            pend_vld_reg <= 1'b0;
            labeled_reg  <= '0;
        end else begin
            state_reg    <= state_next;
            ctr_reg      <= ctr_next;
            out_vld_reg  <= out_vld_next;
            pend_vld_reg <= pend_vld_next;
            labeled_reg  <= labeled_next;
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        src_reg      <= src_next;
        snk_reg      <= snk_next;
        x_reg        <= x_next;
        amtx_reg     <= amtx_next;
        aug_amt_reg  <= aug_amt_next;
        total_reg    <= total_next;
        head_reg     <= head_next;
        tail_reg     <= tail_next;
        scan_reg     <= scan_next;
        steps_reg    <= steps_next;
        pend_idx_reg <= pend_idx_next;
        aug_addr_reg <= aug_addr_next;
        aug_fwd_reg  <= aug_fwd_next;
        out_flow_reg <= out_flow_next;
    end

    assign m_valid    = out_vld_reg;
    assign m_max_flow = out_flow_reg;
endmodule
`default_nettype wire

// ===== rtl/mfba_checker.sv =====
// port level checks for the max flow bfs augment unit and their binding
`default_nettype none
module mfba_checker (
    input wire logic                        aclk,
    input wire logic                        aresetn,
    input wire logic                        s_valid,
    input wire logic                        s_ready,
    input wire logic                        s_op,
    input wire logic                        m_valid,
    input wire logic                        m_ready,
    input wire logic [mfba_pkg::AMT_W-1:0]  m_max_flow
);
    import mfba_pkg::*;

    // reset starts the capacity clearing pass, nothing is taken
    a_reset_busy: assert property (@(posedge aclk) !aresetn |=> !s_ready && !m_valid)
        else $error("input ready or result valid right after reset");

    // a load transfer leaves the input ready in the following cycle
    a_load_one_cycle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_op == OP_LOAD |=> s_ready)
        else $error("not ready again after a load transfer");

    // a compute transfer keeps the input side busy
    a_compute_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_op == OP_COMPUTE |=> !s_ready)
        else $error("ready directly after a compute transfer");

    // a stalled result holds
    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_max_flow))
        else $error("stalled result dropped or changed");
endmodule

bind max_flow_bfs_augment_unit mfba_checker u_mfba_checker (
    .aclk       (aclk),
    .aresetn    (aresetn),
    .s_valid    (s_valid),
    .s_ready    (s_ready),
    .s_op       (s_op),
    .m_valid    (m_valid),
    .m_ready    (m_ready),
    .m_max_flow (m_max_flow)
);
`default_nettype wire

// ===== tb/max_flow_bfs_augment_checker.sv =====
// checker for the max flow unit: predicts each result and compares transfers
`timescale 1ns / 100ps
`default_nettype none
module max_flow_bfs_augment_checker (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        cfg_we,
    input  wire logic [mfba_pkg::CNT_W-1:0]  cfg_wdata,
    input  wire logic                        s_valid,
    input  wire logic                        s_ready,
    input  wire logic                        s_op,
    input  wire logic [mfba_pkg::VERT_W-1:0] s_from_vertex,
    input  wire logic [mfba_pkg::VERT_W-1:0] s_to_vertex,
    input  wire logic [mfba_pkg::CAP_W-1:0]  s_capacity,
    input  wire logic [mfba_pkg::VERT_W-1:0] s_source,
    input  wire logic [mfba_pkg::VERT_W-1:0] s_sink,
    input  wire logic                        m_valid,
    input  wire logic                        m_ready,
    input  wire logic [mfba_pkg::AMT_W-1:0]  m_max_flow,
    output int                               fail_count,
    output int                               flows_pending
);
    import mfba_pkg::*;

    localparam int UNLABELED = 0;
    localparam int FORWARD   = 1;
    localparam int BACKWARD  = 2;

    // predictor state
    logic [CNT_W-1:0] vcount;
    int unsigned      cap_mat  [NVERT*NVERT];
    int unsigned      flow_mat [NVERT*NVERT];
    int               dir_of   [NVERT];
    int unsigned      pred_of  [NVERT];
    int unsigned      amt_of   [NVERT];
    logic [AMT_W-1:0] flow_q   [$];

    // one breadth-first labelling pass; returns 1 when the sink gets labelled
    function automatic bit label_graph(int unsigned n, int unsigned s, int unsigned t);
        int unsigned bfs_q [NVERT];
        int unsigned head, tail, x, cxi, fxi, fix;
        head = 0;
        tail = 0;
        for (int i = 0; i < NVERT; i++) dir_of[i] = UNLABELED;
        dir_of[s] = FORWARD;
        pred_of[s] = s;
        amt_of[s] = SOURCE_AMOUNT;
        bfs_q[tail++] = s;
        while (head < tail) begin
            x = bfs_q[head++];
            for (int unsigned i = 0; i < n; i++) begin
                cxi = cap_mat[x*NVERT+i];
                fxi = flow_mat[x*NVERT+i];
                fix = flow_mat[i*NVERT+x];
                if (dir_of[i] != UNLABELED) continue;
                if (cxi > fxi) begin
                    dir_of[i] = FORWARD;
                    pred_of[i] = x;
                    amt_of[i] = (cxi - fxi < amt_of[x]) ? cxi - fxi : amt_of[x];
                end else if (fix > 0) begin
                    dir_of[i] = BACKWARD;
                    pred_of[i] = x;
                    amt_of[i] = (fix < amt_of[x]) ? fix : amt_of[x];
                end else begin
                    continue;
                end
                if (tail < NVERT) bfs_q[tail++] = i;
            end
            if (dir_of[t] != UNLABELED) return 1'b1;
        end
        return 1'b0;
    endfunction

    // full edmonds-karp run, saturated to the output width
    function automatic logic [AMT_W-1:0] predict_max_flow(int unsigned s, int unsigned t);
        int unsigned n, x, p, steps, amount;
        longint unsigned total;
        total = 0;
        n = vcount;
        if (n < VCOUNT_MIN) n = VCOUNT_MIN;
        if (n > VCOUNT_MAX) n = VCOUNT_MAX;
        for (int i = 0; i < NVERT*NVERT; i++) flow_mat[i] = 0;
        if (s == t || s >= n || t >= n) return '0;
        while (label_graph(n, s, t)) begin
            amount = amt_of[t];
            x = t;
            steps = 0;
            total += amount;
            while (x != s && steps < n) begin
                p = pred_of[x] % NVERT;
                if (dir_of[x] == FORWARD) flow_mat[p*NVERT+x] += amount;
                else flow_mat[x*NVERT+p] -= amount;
                x = p;
                steps++;
            end
        end
        if (total > OUT_MAX) total = OUT_MAX;
        return total[AMT_W-1:0];
    endfunction

    task automatic report_mismatch(string what);
        $display("mismatch at %0t: %s", $realtime, what);
        fail_count++;
    endtask

    assign flows_pending = flow_q.size();

    // watch both channels
    always @(posedge aclk) begin
        logic [AMT_W-1:0] want;
        if (!aresetn) begin
            vcount <= VCOUNT_RESET;
            for (int i = 0; i < NVERT*NVERT; i++) cap_mat[i] = 0;
            flow_q.delete();
            fail_count = 0;
        end else begin
            if (cfg_we) vcount <= cfg_wdata;
            if (s_valid && s_ready) begin
                if (s_op == OP_LOAD) cap_mat[s_from_vertex*NVERT+s_to_vertex] = s_capacity;
                else flow_q.push_back(predict_max_flow(s_source, s_sink));
            end
            if (m_valid && m_ready) begin
                if (flow_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected result %0d", m_max_flow));
                end else begin
                    want = flow_q.pop_front();
                    if (m_max_flow !== want)
                        report_mismatch($sformatf("max_flow %0d, expected %0d",
                                                  m_max_flow, want));
                end
            end
        end
    end
endmodule
`default_nettype wire

// ===== tb/tb_max_flow_bfs_augment_unit.sv =====
// testbench top for the max flow unit: stimulus, watchdog and verdict
`timescale 1ns / 100ps
`default_nettype none
module tb_max_flow_bfs_augment_unit;
    import mfba_pkg::*;

    localparam int STALL_LIMIT = 2000000;

    logic                aclk;
    logic                aresetn;
    logic                cfg_we;
    logic [CNT_W-1:0]    cfg_wdata;
    logic                s_valid;
    logic                s_ready;
    logic                s_op;
    logic [VERT_W-1:0]   s_from_vertex;
    logic [VERT_W-1:0]   s_to_vertex;
    logic [CAP_W-1:0]    s_capacity;
    logic [VERT_W-1:0]   s_source;
    logic [VERT_W-1:0]   s_sink;
    logic                m_valid;
    logic                m_ready;
    logic [AMT_W-1:0]    m_max_flow;
    int                  fail_count;
    int                  flows_pending;
    int                  quiet_cycles;
    int                  recv_wait;

    max_flow_bfs_augment_unit dut (.*);
    max_flow_bfs_augment_checker checker_i (.*);

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // receiver: random stall before each result transfer
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            recv_wait <= $urandom_range(0, 16);
        end else if (m_ready && m_valid) begin
            recv_wait <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
            m_ready <= 1'b0;
        end else if (recv_wait > 0) begin
            recv_wait <= recv_wait - 1;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("max_flow_bfs_augment_unit regression: fail");
            $finish;
        end
    end

    // valid stays up between back to back transfers, drops only for a gap
    task automatic send_item(logic op, int u, int v, int cap, int s, int t, bit gaps);
        int gap;
        gap = gaps ? (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16)) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_op <= op;
        s_from_vertex <= VERT_W'(u);
        s_to_vertex <= VERT_W'(v);
        s_capacity <= CAP_W'(cap);
        s_source <= VERT_W'(s);
        s_sink <= VERT_W'(t);
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic load_edge(int u, int v, int cap, bit gaps = 1);
        send_item(OP_LOAD, u, v, cap, $urandom_range(0, 63), $urandom_range(0, 63), gaps);
    endtask

    task automatic run_flow(int s, int t, bit gaps = 1);
        send_item(OP_COMPUTE, $urandom_range(0, 63), $urandom_range(0, 63),
                  $urandom_range(0, 65535), s, t, gaps);
    endtask

    // stop sending, wait until all results are back, then let the unit settle
    task automatic drain;
        s_valid <= 1'b0;
        @(posedge aclk);
        while (flows_pending != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic set_vertex_count(int n);
        drain();
        cfg_we <= 1'b1;
        cfg_wdata <= CNT_W'(n);
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    initial begin
        int n, ends;
        aresetn = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        s_valid = 1'b0;
        s_op = OP_LOAD;
        s_from_vertex = '0;
        s_to_vertex = '0;
        s_capacity = '0;
        s_source = '0;
        s_sink = '0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: chain with bottleneck, parallel paths, backward edge, extremes
        load_edge(0, 1, 10, 0);
        load_edge(1, 2, 4, 0);
        load_edge(0, 2, 65535);
        load_edge(1, 1, 500);
        run_flow(0, 2);
        run_flow(2, 0);
        run_flow(5, 5);
        load_edge(2, 3, 7);
        load_edge(0, 3, 3);
        load_edge(1, 3, 9);
        run_flow(0, 3);
        load_edge(63, 62, 65535);
        load_edge(0, 63, 65535);
        load_edge(62, 3, 65535);
        run_flow(0, 3);
        run_flow(63, 62);
        run_flow(0, 63);
        set_vertex_count(2);
        run_flow(0, 1);
        run_flow(0, 3);
        set_vertex_count(0);
        run_flow(0, 1);
        set_vertex_count(127);
        run_flow(0, 3);
        // hold off until everything is back
        drain();

        // random phases over several vertex counts, small graphs mostly
        for (int ph = 0; ph < 6; ph++) begin
            n = (ph == 5) ? 64 : $urandom_range(2, 12);
            set_vertex_count((ph == 4) ? $urandom_range(0, 127) : n);
            for (int k = 0; k < 16; k++) begin
                if ($urandom_range(0, 3) == 0) begin
                    ends = (ph == 5) ? 63 : n - 1;
                    run_flow($urandom_range(0, ends), $urandom_range(0, ends));
                end else if ($urandom_range(0, 9) == 0) begin
                    load_edge($urandom_range(0, 63), $urandom_range(0, 63),
                              $urandom_range(0, 65535));
                end else begin
                    load_edge($urandom_range(0, n - 1), $urandom_range(0, n - 1),
                              ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 65535));
                end
            end
            run_flow(0, n - 1);
        end

        drain();
        repeat (200) @(posedge aclk);
        if (fail_count == 0)
            $display("max_flow_bfs_augment_unit regression: pass");
        else
            $display("max_flow_bfs_augment_unit regression: fail");
        $finish;
    end
endmodule
`default_nettype wire
